>>> hdl/vhd_pkg.sv
package vhd_pkg;

    // Coordinate and result widths
    localparam int CoordWidth = 16;
    localparam int HeadW      = 9;

    // Angle search: 90 thresholds at k + 0.5 degrees
    localparam int Steps    = 90;
    localparam int AngW     = $clog2(Steps + 1);
    localparam int IdxW     = $clog2(Steps);
    localparam int NumCells = AngW;

    // Fixed-point Q2.62 and the split of a table word into two halves
    localparam int QW    = 64;
    localparam int HalfW = QW / 2;
    localparam int ProdW = CoordWidth + HalfW;
    localparam int SumW  = CoordWidth + QW;

    localparam logic [QW-1:0] PiQ62  = 64'hC90FDAA22168C234;
    localparam logic [QW-1:0] OneQ62 = 64'h4000000000000000;

    typedef logic [CoordWidth-1:0] t_mag;
    typedef logic [AngW-1:0]       t_ang;
    typedef logic [IdxW-1:0]       t_idx;
    typedef logic [HeadW-1:0]      t_head;
    typedef logic [QW-1:0]         t_q62;

    localparam t_ang FirstStep = t_ang'(1) << (AngW - 1);
    localparam t_ang AngLimit  = t_ang'(Steps);

    // Headings of the axes
    localparam t_head Head0   = t_head'(0);
    localparam t_head Head90  = t_head'(90);
    localparam t_head Head180 = t_head'(180);
    localparam t_head Head270 = t_head'(270);
    localparam t_head Head360 = t_head'(360);

    // Item class: result already known on an axis, or needs the angle search
    typedef enum logic {
        CLS_AXIS,
        CLS_QUAD
    } t_cls;

    // Item as it travels down the chain
    typedef struct packed {
        t_mag  ax;
        t_mag  ay;
        logic  xn;
        logic  yn;
        t_cls  cls;
        t_head fixed_head;
        t_ang  r;
        t_ang  step;
    } t_vec;

    typedef struct packed {
        t_q62 s;
        t_q62 c;
    } t_sc;

    typedef t_q62 t_tab [Steps];

    // Truncated Q2.62 product
    function automatic t_q62 mulq(t_q62 a, t_q62 b);
        logic [2*QW-1:0] p;
        p = {{QW{1'b0}}, a} * {{QW{1'b0}}, b};
        return p[2*QW-3:QW-2];
    endfunction

    // Taylor series sine/cosine, terms added in order of rising power
    function automatic t_sc sin_cos(t_q62 x);
        t_q62 x2, x3, x4, x5, x6, x7, x8;
        t_sc  o;
        x2 = mulq(x, x);
        x3 = mulq(x2, x);
        x4 = mulq(x2, x2);
        x5 = mulq(x4, x);
        x6 = mulq(x4, x2);
        x7 = mulq(x6, x);
        x8 = mulq(x4, x4);
        o.s = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
        o.c = OneQ62 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
        return o;
    endfunction

    // Threshold table: start at half a degree, rotate by one degree per entry
    function automatic t_tab build_table(logic want_sin);
        t_sc  hf;
        t_sc  dg;
        t_tab ct;
        t_tab st;
        hf = sin_cos(PiQ62 / 64'd360);
        dg = sin_cos(PiQ62 / 64'd180);
        ct[0] = hf.c;
        st[0] = hf.s;
        for (int k = 1; k < Steps; k++) begin
            ct[k] = mulq(ct[k-1], dg.c) - mulq(st[k-1], dg.s);
            st[k] = mulq(st[k-1], dg.c) + mulq(ct[k-1], dg.s);
        end
        if (want_sin) begin
            return st;
        end
        return ct;
    endfunction

    localparam t_tab CosTab = build_table(1'b0);
    localparam t_tab SinTab = build_table(1'b1);

endpackage

>>> hdl/vhd_in_if.sv
interface vhd_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [vhd_pkg::CoordWidth-1:0] start_x;
    logic signed [vhd_pkg::CoordWidth-1:0] start_y;
    logic signed [vhd_pkg::CoordWidth-1:0] end_x;
    logic signed [vhd_pkg::CoordWidth-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> hdl/vhd_out_if.sv
interface vhd_out_if;
    logic                 valid;
    logic                 ready;
    vhd_pkg::t_head       heading_deg;

    modport source (output valid, heading_deg, input ready);
    modport sink   (input valid, heading_deg, output ready);
endinterface

>>> hdl/vhd_front.sv
module vhd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vhd_in_if.sink        i_vec,
    output logic          o_valid,
    input  logic          i_ready,
    output vhd_pkg::t_vec o_data
);

    logic                                 r_valid;
    vhd_pkg::t_vec                        r_data;
    vhd_pkg::t_vec                        n_data;
    logic signed [vhd_pkg::CoordWidth:0] dx;
    logic signed [vhd_pkg::CoordWidth:0] dy;
    logic [vhd_pkg::CoordWidth:0]        adx;
    logic [vhd_pkg::CoordWidth:0]        ady;
    logic                                 take;

    assign i_vec.ready = !r_valid || i_ready;
    assign take        = i_vec.valid && i_vec.ready;

    // Differences at one extra bit, then magnitudes and signs
    always_comb begin
        dx  = (vhd_pkg::CoordWidth+1)'(i_vec.end_x) - (vhd_pkg::CoordWidth+1)'(i_vec.start_x);
        dy  = (vhd_pkg::CoordWidth+1)'(i_vec.end_y) - (vhd_pkg::CoordWidth+1)'(i_vec.start_y);
        adx = dx[vhd_pkg::CoordWidth] ? -dx : dx;
        ady = dy[vhd_pkg::CoordWidth] ? -dy : dy;
    end

    // Classify: zero vector and axes are settled here
    always_comb begin
        n_data.ax   = adx[vhd_pkg::CoordWidth-1:0];
        n_data.ay   = ady[vhd_pkg::CoordWidth-1:0];
        n_data.xn   = dx[vhd_pkg::CoordWidth];
        n_data.yn   = dy[vhd_pkg::CoordWidth];
        n_data.r    = '0;
        n_data.step = vhd_pkg::FirstStep;
        n_data.cls  = vhd_pkg::CLS_AXIS;
        if (adx == '0 && ady == '0) begin
            n_data.fixed_head = vhd_pkg::Head0;
        end else if (adx == '0) begin
            n_data.fixed_head = dy[vhd_pkg::CoordWidth] ? vhd_pkg::Head0 : vhd_pkg::Head180;
        end else if (ady == '0) begin
            n_data.fixed_head = dx[vhd_pkg::CoordWidth] ? vhd_pkg::Head270 : vhd_pkg::Head90;
        end else begin
            n_data.fixed_head = vhd_pkg::Head0;
            n_data.cls        = vhd_pkg::CLS_QUAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_vec.ready) begin
            r_valid <= i_vec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/vhd_cell.sv
module vhd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vhd_pkg::t_vec i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output vhd_pkg::t_vec o_data
);

    // Partial products of one threshold test
    typedef struct packed {
        vhd_pkg::t_vec           v;
        logic                    ok;
        vhd_pkg::t_ang           cand;
        logic [vhd_pkg::ProdW-1:0] ly_hi;
        logic [vhd_pkg::ProdW-1:0] ly_lo;
        logic [vhd_pkg::ProdW-1:0] rx_hi;
        logic [vhd_pkg::ProdW-1:0] rx_lo;
    } t_prod;

    logic                     r_a_valid;
    t_prod                    r_a;
    t_prod                    n_a;
    logic                     r_b_valid;
    vhd_pkg::t_vec            r_b;
    vhd_pkg::t_vec            n_b;
    logic                     a_ready;
    logic                     b_ready;
    vhd_pkg::t_idx            idx;
    vhd_pkg::t_q62            cos_k;
    vhd_pkg::t_q62            sin_k;
    logic [vhd_pkg::SumW-1:0] lhs;
    logic [vhd_pkg::SumW-1:0] rhs;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // First half: probe candidate r + step, look up its threshold, multiply
    always_comb begin
        n_a.v    = i_data;
        n_a.cand = i_data.r + i_data.step;
        n_a.ok   = n_a.cand <= vhd_pkg::AngLimit;
        idx      = n_a.ok ? vhd_pkg::t_idx'(n_a.cand - vhd_pkg::t_ang'(1)) : '0;
        cos_k    = vhd_pkg::CosTab[idx];
        sin_k    = vhd_pkg::SinTab[idx];
        n_a.ly_hi = vhd_pkg::ProdW'(i_data.ay) * vhd_pkg::ProdW'(cos_k[vhd_pkg::QW-1:vhd_pkg::HalfW]);
        n_a.ly_lo = vhd_pkg::ProdW'(i_data.ay) * vhd_pkg::ProdW'(cos_k[vhd_pkg::HalfW-1:0]);
        n_a.rx_hi = vhd_pkg::ProdW'(i_data.ax) * vhd_pkg::ProdW'(sin_k[vhd_pkg::QW-1:vhd_pkg::HalfW]);
        n_a.rx_lo = vhd_pkg::ProdW'(i_data.ax) * vhd_pkg::ProdW'(sin_k[vhd_pkg::HalfW-1:0]);
    end

    // Second half: |dy|*cos > |dx|*sin decides this bit of r
    always_comb begin
        lhs = (vhd_pkg::SumW'(r_a.ly_hi) << vhd_pkg::HalfW) + vhd_pkg::SumW'(r_a.ly_lo);
        rhs = (vhd_pkg::SumW'(r_a.rx_hi) << vhd_pkg::HalfW) + vhd_pkg::SumW'(r_a.rx_lo);
        n_b      = r_a.v;
        n_b.step = r_a.v.step >> 1;
        if (r_a.ok && lhs > rhs) begin
            n_b.r = r_a.cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a <= n_a;
        end
        if (b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;

endmodule

>>> hdl/vhd_back.sv
module vhd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vhd_pkg::t_vec i_data,
    vhd_out_if.source     o_head
);

    logic           r_valid;
    vhd_pkg::t_head r_head;
    vhd_pkg::t_head n_head;
    vhd_pkg::t_head ang_ext;

    assign o_ready = !r_valid || o_head.ready;
    assign ang_ext = vhd_pkg::t_head'(i_data.r);

    // Map the rounded angle into its quadrant; axis items keep their fixed heading
    always_comb begin
        case (i_data.cls)
            vhd_pkg::CLS_QUAD: begin
                if (!i_data.xn && i_data.yn) begin
                    n_head = vhd_pkg::Head90 - ang_ext;
                end else if (!i_data.xn) begin
                    n_head = vhd_pkg::Head90 + ang_ext;
                end else if (!i_data.yn) begin
                    n_head = vhd_pkg::Head270 - ang_ext;
                end else begin
                    n_head = vhd_pkg::Head270 + ang_ext;
                end
            end
            default: begin
                n_head = i_data.fixed_head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_head <= n_head;
        end
    end

    assign o_head.valid       = r_valid;
    assign o_head.heading_deg = r_head;

endmodule

>>> hdl/vector_heading_degrees_top.sv
// Vector heading in whole degrees.
// Input channel i_vec carries one request: start and end points as signed
// coordinates. Output channel o_head returns one heading_deg per request,
// 0..360, with negative y at 0, positive x at 90, positive y at 180 and
// negative x at 270; a zero vector gives 0.
// Both channels use valid/ready; a request moves when both are high.
// From accepted request to valid result: the front register forms
// differences and magnitudes, seven search cells of two stages each
// find the rounded angle one bit at a time, and the output register takes
// the angle mapped into its quadrant.
// Throughput is one request per cycle; every stage holds its own valid
// bit, so the chain keeps accepting while bubbles remain behind a result
// that waits. Each cell carries four multipliers of coordinate width by
// 32 bits in its first stage and one 80-bit compare in its second.
// When the receiver stalls, stages fill up from the output back; i_vec.ready
// drops only when all 16 stages hold a request.
// Synchronous reset empties every stage; no result is pending afterward.
module vector_heading_degrees_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vhd_in_if.sink    i_vec,
    vhd_out_if.source o_head
);

    logic          link_valid [vhd_pkg::NumCells+1];
    logic          link_ready [vhd_pkg::NumCells+1];
    vhd_pkg::t_vec link_data  [vhd_pkg::NumCells+1];

    vhd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (i_vec),
        .o_valid (link_valid[0]),
        .i_ready (link_ready[0]),
        .o_data  (link_data[0])
    );

    // Row of search cells, one bit of the angle each
    for (genvar g = 0; g < vhd_pkg::NumCells; g++) begin : g_cell
        vhd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[g]),
            .o_ready (link_ready[g]),
            .i_data  (link_data[g]),
            .o_valid (link_valid[g+1]),
            .i_ready (link_ready[g+1]),
            .o_data  (link_data[g+1])
        );
    end

    vhd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (link_valid[vhd_pkg::NumCells]),
        .o_ready (link_ready[vhd_pkg::NumCells]),
        .i_data  (link_data[vhd_pkg::NumCells]),
        .o_head  (o_head)
    );

endmodule

>>> hdl/vhd_checker.sv
module vhd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input vhd_pkg::t_head i_out_head
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Reset empties the whole chain, so a request can enter
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready right after reset");

    // Heading stays in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_head <= vhd_pkg::Head360)
        else $error("heading out of range");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_head))
        else $error("stalled result changed");

endmodule

bind vector_heading_degrees_top vhd_checker u_vhd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_head.valid),
    .i_out_ready (o_head.ready),
    .i_out_head  (o_head.heading_deg)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HalfPeriod  = 4;
    localparam int ResetCycles = 10;
    localparam int DrainCycles = 24;
    localparam int NumRandom   = 1150;
    localparam int NumFlat     = 250;
    localparam int NumStall    = 48;
    localparam int StallHold   = 64;
    localparam int SlopeSteps  = 90;

    typedef logic signed [vhd_pkg::CoordWidth-1:0] t_coord;

    // One pending heading and the request it came from
    typedef struct {
        vhd_pkg::t_head head;
        t_coord         sx;
        t_coord         sy;
        t_coord         ex;
        t_coord         ey;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    vhd_in_if  in_if ();
    vhd_out_if out_if ();

    vector_heading_degrees_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vec  (in_if),
        .o_head (out_if)
    );

    // Half-degree slope thresholds, Q2.62
    logic [63:0] thr_cos [SlopeSteps];
    logic [63:0] thr_sin [SlopeSteps];

    t_pending heading_q [$];
    int       err_count = 0;
    bit       idling    = 1'b1;
    int       hold_left = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #HalfPeriod i_clk = ~i_clk;

    // Q2.62 product, truncated
    function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // sin/cos by Taylor series; rotate half a degree by one degree per entry
    task automatic build_thresholds();
        logic [63:0] ang [2];
        logic [63:0] sv [2];
        logic [63:0] cv [2];
        logic [63:0] p2, p3, p4, p5, p6, p7, p8;
        ang[0] = vhd_pkg::PiQ62 / 64'd360;
        ang[1] = vhd_pkg::PiQ62 / 64'd180;
        for (int i = 0; i < 2; i++) begin
            p2 = q62_mul(ang[i], ang[i]);
            p3 = q62_mul(p2, ang[i]);
            p4 = q62_mul(p2, p2);
            p5 = q62_mul(p4, ang[i]);
            p6 = q62_mul(p4, p2);
            p7 = q62_mul(p6, ang[i]);
            p8 = q62_mul(p4, p4);
            sv[i] = ang[i] - p3 / 64'd6 + p5 / 64'd120 - p7 / 64'd5040;
            cv[i] = vhd_pkg::OneQ62 - p2 / 64'd2 + p4 / 64'd24
                    - p6 / 64'd720 + p8 / 64'd40320;
        end
        thr_cos[0] = cv[0];
        thr_sin[0] = sv[0];
        for (int k = 1; k < SlopeSteps; k++) begin
            thr_cos[k] = q62_mul(thr_cos[k-1], cv[1]) - q62_mul(thr_sin[k-1], sv[1]);
            thr_sin[k] = q62_mul(thr_sin[k-1], cv[1]) + q62_mul(thr_cos[k-1], sv[1]);
        end
    endtask

    // Expected heading of (end - start)
    function automatic vhd_pkg::t_head predict_heading(t_coord sx, t_coord sy,
                                                       t_coord ex, t_coord ey);
        logic signed [vhd_pkg::CoordWidth:0] dx;
        logic signed [vhd_pkg::CoordWidth:0] dy;
        logic [vhd_pkg::CoordWidth:0]        ax;
        logic [vhd_pkg::CoordWidth:0]        ay;
        logic [127:0]                        lhs;
        logic [127:0]                        rhs;
        int                                  r;
        dx = ex - sx;
        dy = ey - sy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax == 0 && ay == 0) begin
            return vhd_pkg::Head0;
        end
        if (ax == 0) begin
            return (dy < 0) ? vhd_pkg::Head0 : vhd_pkg::Head180;
        end
        if (ay == 0) begin
            return (dx < 0) ? vhd_pkg::Head270 : vhd_pkg::Head90;
        end
        // count thresholds the slope exceeds; a tie rounds down
        r = 0;
        for (int k = 0; k < SlopeSteps; k++) begin
            lhs = 128'(ay) * 128'(thr_cos[k]);
            rhs = 128'(ax) * 128'(thr_sin[k]);
            if (lhs > rhs) begin
                r++;
            end
        end
        if (dx > 0 && dy < 0) begin
            return vhd_pkg::t_head'(90 - r);
        end else if (dx > 0) begin
            return vhd_pkg::t_head'(90 + r);
        end else if (dy > 0) begin
            return vhd_pkg::t_head'(270 - r);
        end
        return vhd_pkg::t_head'(270 + r);
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    // Drive one request; optional idle burst first; log expectation on accept
    task automatic send_vector(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        t_pending p;
        if (idling && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.start_x <= sx;
        in_if.start_y <= sy;
        in_if.end_x   <= ex;
        in_if.end_y   <= ey;
        do @(posedge i_clk); while (!in_if.ready);
        p.head = predict_heading(sx, sy, ex, ey);
        p.sx   = sx;
        p.sy   = sy;
        p.ex   = ex;
        p.ey   = ey;
        heading_q.push_back(p);
    endtask

    // Sender goes quiet until every pending heading has come back
    task automatic wait_all_done();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (heading_q.size() != 0);
    endtask

    function automatic t_coord pick_corner();
        case ($urandom_range(0, 4))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // Random request: full range, short vectors, axis-aligned, corners
    task automatic send_random();
        t_coord sx, sy, ex, ey;
        int     dxr, dyr;
        sx  = t_coord'($urandom);
        sy  = t_coord'($urandom);
        ex  = t_coord'($urandom);
        ey  = t_coord'($urandom);
        dxr = int'($urandom_range(0, 128)) - 64;
        dyr = int'($urandom_range(0, 128)) - 64;
        case ($urandom_range(0, 9))
            4, 5, 6: begin
                ex = t_coord'(sx + dxr);
                ey = t_coord'(sy + dyr);
            end
            7: begin
                if ($urandom_range(0, 1) != 0) begin
                    ex = sx;
                end else begin
                    ey = sy;
                end
            end
            8: begin
                sx = pick_corner();
                sy = pick_corner();
                ex = pick_corner();
                ey = pick_corner();
            end
            default: ;
        endcase
        send_vector(sx, sy, ex, ey);
    endtask

    // Axes, zero vectors, each quadrant, diagonals, coordinate extremes
    task automatic test_directed();
        send_vector(0, 0, 0, 0);
        send_vector(100, -100, 100, -100);
        send_vector(0, 0, 0, -5);
        send_vector(0, 0, 0, 7);
        send_vector(0, 0, 9, 0);
        send_vector(0, 0, -9, 0);
        send_vector(0, 0, 3, -4);
        send_vector(0, 0, 3, 4);
        send_vector(0, 0, -3, 4);
        send_vector(0, 0, -3, -4);
        send_vector(0, 0, 1, 1);
        send_vector(0, 0, -1, -1);
        send_vector(0, 0, 2, -1);
        send_vector(0, 0, 1, -2);
        send_vector(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_vector(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_vector(-16'sd32768, 0, 16'sd32767, 1);
        send_vector(0, -16'sd32768, 1, 16'sd32767);
        send_vector(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
        send_vector(0, 16'sd32767, 0, -16'sd32768);
        send_vector(-16'sd32768, 5, 16'sd32767, 5);
        send_vector(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        wait_all_done();
    endtask

    task automatic test_random();
        for (int n = 0; n < NumRandom; n++) begin
            send_random();
        end
        wait_all_done();
    endtask

    // Receiver holds off long enough for the whole chain to fill
    task automatic test_backpressure();
        idling = 1'b0;
        @(negedge i_clk);
        hold_left = StallHold;
        for (int n = 0; n < NumStall; n++) begin
            send_random();
        end
        wait_all_done();
        idling = 1'b1;
    endtask

    // Closing stretch: both sides at full rate
    task automatic test_full_rate();
        idling = 1'b0;
        for (int n = 0; n < NumFlat; n++) begin
            send_random();
        end
        wait_all_done();
    endtask

    // Receiver: random stall bursts, or a long hold when asked
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Compare each returned heading with the oldest pending one
    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (heading_q.size() == 0) begin
                report_mismatch($sformatf("heading %0d with no request pending",
                                          out_if.heading_deg));
            end else begin
                p = heading_q.pop_front();
                if (out_if.heading_deg !== p.head) begin
                    report_mismatch($sformatf(
                        "(%0d,%0d)->(%0d,%0d): heading_deg %0d, want %0d",
                        p.sx, p.sy, p.ex, p.ey, out_if.heading_deg, p.head));
                end
            end
        end
    end

    initial begin
        build_thresholds();
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.start_x <= '0;
        in_if.start_y <= '0;
        in_if.end_x   <= '0;
        in_if.end_y   <= '0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        test_backpressure();
        test_full_rate();

        repeat (DrainCycles) @(posedge i_clk);
        if (err_count == 0 && heading_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
